// ===== src/lie_pkg.sv =====
// Shared types and constants for the Lagrange interpolation evaluator.
// No dependencies.
package lie_pkg;

  localparam int NODES_DEFAULT = 8;
  localparam int IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic signed [63:0] P_ONE = 64'sd65536;
  localparam logic signed [63:0] P_LIMIT = 64'sd35184372088831;

  typedef struct packed {
    logic command;
    logic [2:0] node_index;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] curve_y;
    logic [1:0] status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DUP, S_PINIT, S_MUL, S_DIV, S_CLAMP, S_TERM, S_TDIV, S_ACC, S_DONE
  } eval_state_t;

endpackage

// ===== src/lie_front.sv =====
// Front: accepts input words and queues them for the evaluator.
// Depends on lie_pkg.
module lie_front #(
  parameter int DEPTH = lie_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  lie_pkg::in_word_t in_word,
  output logic q_valid,
  input  logic q_take,
  output lie_pkg::in_word_t q_word
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lie_pkg::in_word_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (AW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign q_word = mem[rptr];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count overflow");
  a_full_nopush: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> count == (AW+1)'(DEPTH)) else $error("full queue changed");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    !q_valid && !push |=> !q_valid) else $error("queue filled without push");
`endif
endmodule

// ===== src/lie_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// No dependencies.
module lie_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic busy,
  output logic done,
  output logic signed [63:0] quo
);
  logic [63:0] rem;
  logic [63:0] q;
  logic [63:0] d;
  logic neg;
  logic [6:0] cnt;
  logic [64:0] trial;

  assign trial = {rem[63:0], q[63]} - {1'b0, d};
  assign quo = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= num[63] ? 64'(-num) : 64'(num);
      d <= den[63] ? 64'(-den) : 64'(den);
      neg <= num[63] ^ den[63];
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        q <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
    end
  end
endmodule

// ===== src/lie_back.sv =====
// Back: node store, duplicate check and Lagrange evaluation sequencer.
// Depends on lie_pkg and lie_div.
module lie_back #(
  parameter int NODES = lie_pkg::NODES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  lie_pkg::in_word_t q_word,
  output logic res_valid,
  input  logic res_take,
  output lie_pkg::out_word_t res_word
);
  localparam int NW = $clog2(NODES);

  logic [NODES-1:0] nvalid;
  logic signed [15:0] xs [NODES];
  logic signed [15:0] ys [NODES];

  lie_pkg::eval_state_t state, state_next;
  logic [NW-1:0] ii, jj;
  logic signed [15:0] xq;
  logic signed [63:0] p, prod, sum;
  logic sat;
  logic dup;
  logic signed [16:0] b_val;
  logic mul_go;
  logic div_start, div_busy, div_done;
  logic signed [63:0] div_num, div_den, div_q;
  logic signed [15:0] xi, xj, yi;
  logic last_j, last_i, i_eq_j;

  assign xi = nvalid[ii] ? xs[ii] : 16'sd0;
  assign xj = nvalid[jj] ? xs[jj] : 16'sd0;
  assign yi = nvalid[ii] ? ys[ii] : 16'sd0;
  assign last_j = (jj == NW'(NODES - 1));
  assign last_i = (ii == NW'(NODES - 1));
  assign i_eq_j = (ii == jj);

  lie_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      lie_pkg::S_IDLE: begin
        if (q_valid && q_word.command == lie_pkg::CMD_EVAL) begin
          state_next = lie_pkg::S_DUP;
        end
      end
      lie_pkg::S_DUP: begin
        if (!i_eq_j && xi == xj) state_next = lie_pkg::S_DONE;
        else if (last_i && last_j) state_next = lie_pkg::S_PINIT;
      end
      lie_pkg::S_PINIT: state_next = lie_pkg::S_MUL;
      lie_pkg::S_MUL: begin
        if (i_eq_j) state_next = last_j ? lie_pkg::S_TERM : lie_pkg::S_MUL;
        else state_next = lie_pkg::S_DIV;
      end
      lie_pkg::S_DIV: if (div_done) state_next = lie_pkg::S_CLAMP;
      lie_pkg::S_CLAMP: state_next = last_j ? lie_pkg::S_TERM : lie_pkg::S_MUL;
      lie_pkg::S_TERM: state_next = lie_pkg::S_TDIV;
      lie_pkg::S_TDIV: state_next = lie_pkg::S_ACC;
      lie_pkg::S_ACC: state_next = last_i ? lie_pkg::S_DONE : lie_pkg::S_PINIT;
      lie_pkg::S_DONE: if (!res_valid) state_next = lie_pkg::S_IDLE;
      default: state_next = lie_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_take = 1'b0;
    div_start = 1'b0;
    mul_go = 1'b0;
    unique case (state)
      lie_pkg::S_IDLE: q_take = q_valid;
      lie_pkg::S_MUL: mul_go = !i_eq_j;
      lie_pkg::S_DIV: div_start = !div_busy && !div_done && !mul_go;
      default: q_take = 1'b0;
    endcase
  end

  assign div_num = prod;
  assign div_den = 64'(b_val);

  always_ff @(posedge clk) begin
    if (q_take && q_word.command == lie_pkg::CMD_LOAD &&
        32'(q_word.node_index) < NODES) begin
      xs[NW'(q_word.node_index)] <= q_word.x_value;
      ys[NW'(q_word.node_index)] <= q_word.y_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lie_pkg::S_IDLE;
      nvalid <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_take && q_word.command == lie_pkg::CMD_LOAD &&
          32'(q_word.node_index) < NODES) begin
        nvalid[NW'(q_word.node_index)] <= 1'b1;
      end
      if (res_take) res_valid <= 1'b0;
      if (state == lie_pkg::S_DONE && !res_valid) res_valid <= 1'b1;
    end
  end

  logic signed [63:0] clamped;
  logic signed [63:0] term;
  always_comb begin
    clamped = div_q;
    if (div_q > lie_pkg::P_LIMIT) clamped = lie_pkg::P_LIMIT;
    else if (div_q < -lie_pkg::P_LIMIT) clamped = -lie_pkg::P_LIMIT;
    term = prod >>> 16;
    if (prod[63] && prod[15:0] != 16'd0) term = term + 64'sd1;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lie_pkg::S_IDLE: begin
        xq <= q_word.x_value;
        ii <= '0;
        jj <= '0;
        sum <= '0;
        sat <= 1'b0;
        dup <= 1'b0;
      end
      lie_pkg::S_DUP: begin
        if (!i_eq_j && xi == xj) begin
          dup <= 1'b1;
        end else if (last_j) begin
          jj <= '0;
          ii <= last_i ? '0 : ii + 1'b1;
        end else begin
          jj <= jj + 1'b1;
        end
      end
      lie_pkg::S_PINIT: begin
        p <= lie_pkg::P_ONE;
        jj <= '0;
      end
      lie_pkg::S_MUL: begin
        if (i_eq_j) begin
          if (!last_j) jj <= jj + 1'b1;
        end else begin
          b_val <= 17'(xi) - 17'(xj);
          prod <= p * 64'(17'(xq) - 17'(xj));
        end
      end
      lie_pkg::S_CLAMP: begin
        p <= clamped;
        if (clamped != div_q) sat <= 1'b1;
        if (!last_j) jj <= jj + 1'b1;
      end
      lie_pkg::S_TERM: prod <= 64'(yi) * p;
      lie_pkg::S_TDIV: prod <= term;
      lie_pkg::S_ACC: begin
        sum <= sum + prod;
        ii <= ii + 1'b1;
      end
      lie_pkg::S_DONE: begin
        if (!res_valid) begin
          if (dup) begin
            res_word.curve_y <= '0;
            res_word.status <= lie_pkg::ST_DUP;
          end else if (sum > 64'sd2147483647) begin
            res_word.curve_y <= 32'sh7FFFFFFF;
            res_word.status <= lie_pkg::ST_SAT;
          end else if (sum < -64'sd2147483648) begin
            res_word.curve_y <= 32'sh80000000;
            res_word.status <= lie_pkg::ST_SAT;
          end else begin
            res_word.curve_y <= sum[31:0];
            res_word.status <= sat ? lie_pkg::ST_SAT : lie_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != lie_pkg::S_IDLE |-> !q_take) else $error("took word while busy");
  a_div_only: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == lie_pkg::S_DIV) else $error("stray divide");
  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == lie_pkg::S_DONE) else $error("stray result");
`endif
endmodule

// ===== src/lagrange_interpolation_eval.sv =====
// Lagrange interpolation evaluator: front queue plus evaluation back end.
// An evaluate runs the serial divider in every basis step, once per node pair
// with i != j; a duplicate node x ends it in the pair scan.
// One item is worked at a time.
// Synchronous active-high reset clears control state and marks all nodes unloaded (they read as zero).
module lagrange_interpolation_eval #(
  parameter int NODES = lie_pkg::NODES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  lie_pkg::in_word_t in_word,
  output logic empty,
  input  logic pop,
  output lie_pkg::out_word_t out_word
);
  logic q_valid, q_take, res_valid;
  lie_pkg::in_word_t q_word;

  lie_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_word(in_word),
    .q_valid(q_valid), .q_take(q_take), .q_word(q_word)
  );

  lie_back #(.NODES(NODES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_word(q_word),
    .res_valid(res_valid), .res_take(pop && !empty), .res_word(out_word)
  );

  assign empty = !res_valid;
endmodule
